>>> rtl/osm_pkg.sv
`timescale 1ns / 1ps
package osm_pkg;

  localparam int FFT_SIZE = 64;
  localparam int BIN_W    = 6;
  localparam int NUM_PILOTS = 4;

  // Fixed pilot bin positions of the 64-point symbol.
  localparam logic [BIN_W-1:0] PILOT_BINS [NUM_PILOTS] = '{
    BIN_W'(11), BIN_W'(25), BIN_W'(39), BIN_W'(53)
  };

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(FFT_SIZE - 1);

  // Input transaction kinds carried on tuser.
  typedef enum logic [1:0] {
    OP_DATA     = 2'd0,
    OP_MAP_WR   = 2'd1,
    OP_PILOT_WR = 2'd2
  } op_t;

  // DC, band edges and unused bins are always zero.
  function automatic logic is_guard(input logic [BIN_W-1:0] b);
    return (b <= BIN_W'(5)) || (b == BIN_W'(32)) || (b >= BIN_W'(59));
  endfunction

endpackage

>>> rtl/osm_ram.sv
`timescale 1ns / 1ps
module osm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ofdm_subcarrier_mapper_core.sv
`timescale 1ns / 1ps
// OFDM subcarrier mapper, 64-bin symbols.
// Slave stream: tuser = operation (data sample, map write, pilot write);
// tdata carries the sample / pilot value and the table fields; tlast marks the
// last data sample of a packet. Map and pilot writes leave the block idle; a data
// sample goes through a map read, then a symbol buffer write.
// When the last data slot of a symbol is written the block stops taking input,
// reduces the symbol count modulo the pilot row count (one restoring step per
// cycle), loads the four pilots (one pilot table read and one buffer write per
// pilot) and streams 64 bins on the master side, bin 0 first, tlast on bin 63.
// Each bin takes a buffer read and an output register load, and the next bin is
// loaded only once the current one is taken. If the receiver stalls, the bin
// waits in the output register and the symbol buffer read is held until the
// transaction completes.
// Bins never written this symbol read as zero through a per-bin valid vector,
// which is cleared after each symbol and on a packet end.
// Reset (rst, synchronous) clears the control state and valid bits and sets
// the pilot row count register to 127; map and pilot tables must be loaded.
module ofdm_subcarrier_mapper_core #(
  parameter int DATA_SLOTS     = 48,
  parameter int PILOT_ROWS_MAX = 128,
  parameter int SAMPLE_BITS    = 16,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 15 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 6 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,    // pilot_row_count
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low bit up: sample_i, sample_q, table_row[6:0], pilot_column[1:0],
  // bin_position[5:0], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic [1:0]       s_axis_tuser,   // operation
  input  logic             s_axis_tlast,   // packet_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // tdata, low bit up: bin_i, bin_q, bin_number[5:0], zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast    // last_bin
);
  import osm_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int SLOT_AW = (DATA_SLOTS > 1) ? $clog2(DATA_SLOTS) : 1;
  localparam int ROW_W   = (PILOT_ROWS_MAX > 1) ? $clog2(PILOT_ROWS_MAX) : 1;
  localparam int CNT_W   = $clog2(PILOT_ROWS_MAX + 1);
  localparam int DIV_W   = ROW_W + CNT_W;
  localparam int STEP_W  = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int PIL_DEPTH = PILOT_ROWS_MAX * NUM_PILOTS;
  localparam int PIL_AW  = (PIL_DEPTH > 1) ? $clog2(PIL_DEPTH) : 1;
  localparam int ROW_XW  = (ROW_W > 7) ? ROW_W : 7;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DATA_WR   = 7'b0000010,
    S_MOD       = 7'b0000100,
    S_PIL_RD    = 7'b0001000,
    S_PIL_WR    = 7'b0010000,
    S_EMIT_LOAD = 7'b0100000,
    S_EMIT_HOLD = 7'b1000000
  } state_t;

  state_t state;

  // input field unpack
  logic [SB-1:0]     in_i, in_q;
  logic [6:0]        in_row;
  logic [1:0]        in_col;
  logic [BIN_W-1:0]  in_pos;
  logic [ROW_XW-1:0] in_row_x;
  op_t               in_op;
  logic              in_fire;

  assign in_i     = s_axis_tdata[SB-1:0];
  assign in_q     = s_axis_tdata[2*SB-1:SB];
  assign in_row   = s_axis_tdata[2*SB+6:2*SB];
  assign in_col   = s_axis_tdata[2*SB+8:2*SB+7];
  assign in_pos   = s_axis_tdata[2*SB+14:2*SB+9];
  assign in_row_x = ROW_XW'(in_row);
  assign in_op    = op_t'(s_axis_tuser);

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // control and payload registers
  logic [7:0]         pilot_row_count;
  logic [SLOT_AW-1:0] slot_count;
  logic [ROW_W-1:0]   symbol_count;
  logic [ROW_W-1:0]   rem;           // pilot row under reduction
  logic [DIV_W-1:0]   div_sh;        // shifted row count
  logic [STEP_W-1:0]  step;
  logic [1:0]         pil_k;
  logic [BIN_W-1:0]   bin_cnt;
  logic [FFT_SIZE-1:0] buf_valid;
  logic [2*SB-1:0]    sample_reg;
  logic               last_slot_reg;
  logic               pend_reg;
  logic [SB-1:0]      out_i, out_q;
  logic [BIN_W-1:0]   out_bin;
  logic               out_last;

  // rows actually cycled through
  logic [CNT_W-1:0] rows;
  always_comb begin
    if (pilot_row_count == 8'd0) begin
      rows = CNT_W'(1);
    end else if (32'(pilot_row_count) > PILOT_ROWS_MAX) begin
      rows = CNT_W'(PILOT_ROWS_MAX);
    end else begin
      rows = CNT_W'(pilot_row_count);
    end
  end

  // memories
  logic               map_we;
  logic [SLOT_AW-1:0] map_waddr;
  logic [BIN_W-1:0]   map_rdata;

  logic               pil_we;
  logic [PIL_AW-1:0]  pil_waddr, pil_raddr;
  logic [2*SB-1:0]    pil_rdata;

  logic               buf_we;
  logic [BIN_W-1:0]   buf_waddr, buf_raddr;
  logic [2*SB-1:0]    buf_wdata, buf_rdata;

  assign map_we    = in_fire && (in_op == OP_MAP_WR) && (32'(in_row) < DATA_SLOTS);
  assign map_waddr = SLOT_AW'(in_row);

  assign pil_we    = in_fire && (in_op == OP_PILOT_WR) && (32'(in_row) < PILOT_ROWS_MAX);
  assign pil_waddr = PIL_AW'({in_row_x[ROW_W-1:0], in_col});
  assign pil_raddr = PIL_AW'({rem, pil_k});

  assign buf_we    = (state == S_DATA_WR) || (state == S_PIL_WR);
  assign buf_waddr = (state == S_PIL_WR) ? PILOT_BINS[pil_k] : map_rdata;
  assign buf_wdata = (state == S_PIL_WR) ? pil_rdata : sample_reg;
  // next bin is read while the current one waits to be taken
  assign buf_raddr = (state == S_EMIT_HOLD) ? bin_cnt + BIN_W'(1) : '0;

  osm_ram #(.WIDTH(BIN_W), .DEPTH(DATA_SLOTS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (in_pos),
    .raddr (slot_count),
    .rdata (map_rdata)
  );

  osm_ram #(.WIDTH(2 * SB), .DEPTH(PIL_DEPTH)) u_pilot_ram (
    .clk   (clk),
    .we    (pil_we),
    .waddr (pil_waddr),
    .wdata ({in_q, in_i}),
    .raddr (pil_raddr),
    .rdata (pil_rdata)
  );

  osm_ram #(.WIDTH(2 * SB), .DEPTH(FFT_SIZE)) u_sym_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  logic [DIV_W-1:0] rem_x;
  logic             rem_wrap;
  assign rem_x    = DIV_W'(rem);
  assign rem_wrap = (32'(rem) + 1 >= 32'(rows));

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire && (in_op == OP_DATA)) begin
      sample_reg    <= {in_q, in_i};
      pend_reg      <= s_axis_tlast;
      last_slot_reg <= (32'(slot_count) == DATA_SLOTS - 1);
    end
    if (state == S_EMIT_LOAD) begin
      if (buf_valid[bin_cnt] && !is_guard(bin_cnt)) begin
        {out_q, out_i} <= buf_rdata;
      end else begin
        {out_q, out_i} <= '0;
      end
      out_bin  <= bin_cnt;
      out_last <= (bin_cnt == LAST_BIN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pilot_row_count <= 8'd127;
      slot_count      <= '0;
      symbol_count    <= '0;
      rem             <= '0;
      div_sh          <= '0;
      step            <= '0;
      pil_k           <= '0;
      bin_cnt         <= '0;
      buf_valid       <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pilot_row_count <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && (in_op == OP_DATA)) begin
            state <= S_DATA_WR;
          end
        end
        S_DATA_WR: begin
          if (last_slot_reg) begin
            buf_valid[map_rdata] <= 1'b1;
            slot_count <= '0;
            rem        <= symbol_count;
            div_sh     <= DIV_W'(rows) << (ROW_W - 1);
            step       <= STEP_W'(ROW_W - 1);
            state      <= S_MOD;
          end else if (pend_reg) begin
            // partial symbol dropped
            buf_valid    <= '0;
            slot_count   <= '0;
            symbol_count <= '0;
            state        <= S_IDLE;
          end else begin
            buf_valid[map_rdata] <= 1'b1;
            slot_count <= slot_count + SLOT_AW'(1);
            state      <= S_IDLE;
          end
        end
        S_MOD: begin
          if (rem_x >= div_sh) begin
            rem <= rem - ROW_W'(div_sh);
          end
          div_sh <= div_sh >> 1;
          step   <= step - STEP_W'(1);
          if (step == '0) begin
            pil_k <= '0;
            state <= S_PIL_RD;
          end
        end
        S_PIL_RD: begin
          state <= S_PIL_WR;
        end
        S_PIL_WR: begin
          buf_valid[PILOT_BINS[pil_k]] <= 1'b1;
          pil_k <= pil_k + 2'd1;
          if (pil_k == 2'(NUM_PILOTS - 1)) begin
            if (pend_reg || rem_wrap) begin
              symbol_count <= '0;
            end else begin
              symbol_count <= rem + ROW_W'(1);
            end
            bin_cnt <= '0;
            state   <= S_EMIT_LOAD;
          end else begin
            state <= S_PIL_RD;
          end
        end
        S_EMIT_LOAD: begin
          m_axis_tvalid <= 1'b1;
          state         <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (bin_cnt == LAST_BIN) begin
              buf_valid <= '0;
              state     <= S_IDLE;
            end else begin
              bin_cnt <= bin_cnt + BIN_W'(1);
              state   <= S_EMIT_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = OUT_W'({out_bin, out_q, out_i});
  assign m_axis_tlast = out_last;

endmodule

>>> rtl/osm_checker.sv
`timescale 1ns / 1ps
module osm_checker #(
  parameter int SAMPLE_BITS = 16,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 6 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);
  import osm_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic [BIN_W-1:0] bin_num;
  logic [2*SB-1:0]  bin_val;
  assign bin_num = m_axis_tdata[2*SB+BIN_W-1:2*SB];
  assign bin_val = m_axis_tdata[2*SB-1:0];

  // a stalled bin holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // input is never taken while a symbol drains
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during symbol output");

  a_last_bin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (bin_num == LAST_BIN)))
    else $error("tlast not on last bin");

  a_bin_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |->
      ##2 (m_axis_tvalid && (bin_num == BIN_W'($past(bin_num, 2) + 1'b1))))
    else $error("bins out of order");

  a_guard_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && is_guard(bin_num) |-> (bin_val == '0))
    else $error("guard bin not zero");

endmodule

bind ofdm_subcarrier_mapper_core osm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_osm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import osm_pkg::*;

  localparam int SLOTS      = 48;   // data slots per symbol
  localparam int PILOT_ROWS = 128;  // pilot table rows
  localparam int IN_W       = 48;
  localparam int OUT_W      = 40;
  localparam int SETTLE     = 40;   // row reduction + pilot load + clear, with margin

  // Operation code the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] si;
    logic [15:0] sq;
    logic [6:0]  row;
    logic [1:0]  col;
    logic [5:0]  pos;
    logic        pend;
  } mapper_item_t;

  typedef struct packed {
    logic [15:0] i;
    logic [15:0] q;
    logic [5:0]  num;
    logic        last;
  } bin_t;

  // One directed row: an item repeated reps times, optionally with random
  // sample values, and optionally a hand-written value for one bin of the
  // symbol that the row completes.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] si;
    logic [15:0] sq;
    logic [6:0]  row;
    logic [1:0]  col;
    logic [5:0]  pos;
    logic        pend;
    int          reps;
    logic        rnd;
    logic        chk;
    logic [5:0]  chk_bin;
    logic [15:0] chk_i;
    logic [15:0] chk_q;
  } dir_row_t;

  localparam int DIR_COUNT = 17;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // pilot row 0 with the sample extremes
    '{OP_PILOT_WR, 16'h7FFF, 16'h8000, 7'd0, 2'd0, 6'd0, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_PILOT_WR, 16'h8000, 16'h7FFF, 7'd0, 2'd1, 6'd0, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_PILOT_WR, 16'h0000, 16'hFFFF, 7'd0, 2'd2, 6'd0, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_PILOT_WR, 16'hFFFF, 16'h0000, 7'd0, 2'd3, 6'd0, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    // slot 0 aimed at a guard bin, slot 1 at a pilot bin, slot 47 at bin 63
    '{OP_MAP_WR,   16'h0000, 16'h0000, 7'd0, 2'd0, 6'd0, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_MAP_WR,   16'h0000, 16'h0000, 7'd1, 2'd0, 6'd11, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_MAP_WR,   16'h0000, 16'h0000, 7'd47, 2'd0, 6'd63, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    // map write past the last slot, with packet end: both ignored
    '{OP_MAP_WR,   16'hFFFF, 16'hFFFF, 7'd127, 2'd3, 6'd42, 1'b1, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    // unused operation, every field set
    '{OP_UNUSED,   16'hFFFF, 16'hFFFF, 7'd127, 2'd3, 6'd63, 1'b1, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    // top pilot row
    '{OP_PILOT_WR, 16'h8001, 16'h7FFE, 7'd127, 2'd3, 6'd63, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    // first symbol; pilot must win over the sample mapped to bin 11
    '{OP_DATA,     16'h7FFF, 16'h8000, 7'd0, 2'd0, 6'd0, 1'b0, 1, 1'b0, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_DATA,     16'h0000, 16'h0000, 7'd0, 2'd0, 6'd0, 1'b0, 46, 1'b1, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_DATA,     16'h8000, 16'h7FFF, 7'd0, 2'd0, 6'd0, 1'b0, 1, 1'b0, 1'b1, 6'd11,
      16'h7FFF, 16'h8000},
    // partial symbol dropped by a packet end
    '{OP_DATA,     16'h0000, 16'h0000, 7'd0, 2'd0, 6'd0, 1'b0, 5, 1'b1, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_DATA,     16'h0000, 16'h0000, 7'd0, 2'd0, 6'd0, 1'b1, 1, 1'b1, 1'b0, 6'd0, 16'h0, 16'h0},
    // full symbol ending on a packet end; pilot row restarts at 0
    '{OP_DATA,     16'h0000, 16'h0000, 7'd0, 2'd0, 6'd0, 1'b0, 47, 1'b1, 1'b0, 6'd0, 16'h0, 16'h0},
    '{OP_DATA,     16'h0000, 16'h0000, 7'd0, 2'd0, 6'd0, 1'b1, 1, 1'b0, 1'b1, 6'd53,
      16'hFFFF, 16'h0000}
  };

  // Pilot row counts of the random phases (last one drawn at run time).
  localparam int PHASES = 6;
  localparam logic [7:0] PHASE_ROWS [PHASES] = '{8'd3, 8'd1, 8'd128, 8'd0, 8'd255, 8'd0};

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [7:0]       cfg_wr_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  ofdm_subcarrier_mapper_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Mapper state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [15:0] sym_i [FFT_SIZE];
  logic [15:0] sym_q [FFT_SIZE];
  logic [5:0]  slot_bin [SLOTS];
  bit          slot_loaded [SLOTS];
  logic [15:0] pil_i [PILOT_ROWS][NUM_PILOTS];
  logic [15:0] pil_q [PILOT_ROWS][NUM_PILOTS];
  bit          pil_loaded [PILOT_ROWS][NUM_PILOTS];
  int          slot_cnt;
  int          sym_cnt;          // pilot row of the next symbol
  logic [7:0]  row_cfg;

  bin_t bins_due [$];            // bins still to come out, oldest first
  bin_t last_symbol [FFT_SIZE];  // most recent symbol, for directed checks

  int  mismatch_count;
  int  items_taken;              // transactions that the block acts on
  int  bins_checked;
  bit  src_fast;
  bit  sink_fast;
  bit  long_hold_done;
  bin_t got_bin;
  bin_t want_bin;

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic int rows_used();
    if (row_cfg == 8'd0) return 1;
    if (row_cfg > PILOT_ROWS) return PILOT_ROWS;
    return int'(row_cfg);
  endfunction

  function automatic int next_slot();
    return (slot_cnt >= SLOTS) ? 0 : slot_cnt;
  endfunction

  function automatic bit in_guard_band(input int b);
    return b <= 5 || b == 32 || b >= 59;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Applies one accepted transaction; a completed symbol queues its 64 bins.
  function automatic void map_subcarriers(input mapper_item_t it);
    int b;
    int k;
    int prow;
    int rows;
    bin_t nb;
    case (it.op)
      OP_MAP_WR: begin
        if (it.row < SLOTS) begin
          slot_bin[it.row] = it.pos;
          slot_loaded[it.row] = 1'b1;
        end
      end
      OP_PILOT_WR: begin
        pil_i[it.row][it.col] = it.si;
        pil_q[it.row][it.col] = it.sq;
        pil_loaded[it.row][it.col] = 1'b1;
      end
      OP_DATA: begin
        slot_cnt = next_slot();
        sym_i[slot_bin[slot_cnt]] = it.si;
        sym_q[slot_bin[slot_cnt]] = it.sq;
        slot_cnt++;
        if (slot_cnt >= SLOTS) begin
          rows = rows_used();
          prow = sym_cnt % rows;
          for (k = 0; k < NUM_PILOTS; k++) begin
            sym_i[PILOT_BINS[k]] = pil_i[prow][k];
            sym_q[PILOT_BINS[k]] = pil_q[prow][k];
          end
          for (b = 0; b < FFT_SIZE; b++) begin
            nb.i    = in_guard_band(b) ? 16'h0 : sym_i[b];
            nb.q    = in_guard_band(b) ? 16'h0 : sym_q[b];
            nb.num  = 6'(b);
            nb.last = (b == FFT_SIZE - 1);
            bins_due.push_back(nb);
            last_symbol[b] = nb;
            sym_i[b] = 16'h0;
            sym_q[b] = 16'h0;
          end
          slot_cnt = 0;
          sym_cnt = (prow + 1 >= rows) ? 0 : prow + 1;
        end
        if (it.pend) begin
          for (b = 0; b < FFT_SIZE; b++) begin
            sym_i[b] = 16'h0;
            sym_q[b] = 16'h0;
          end
          slot_cnt = 0;
          sym_cnt = 0;
        end
      end
      default: ;  // unused code: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: random gap, then hold the transaction until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_item(input mapper_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) src_fast = !src_fast;
    gap = src_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.pos, it.col, it.row, it.sq, it.si};
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.pend;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    map_subcarriers(it);
    if (!(it.op == OP_UNUSED || (it.op == OP_MAP_WR && it.row >= SLOTS))) items_taken++;
  endtask

  // Data sample; first loads any map or pilot entry it would read unwritten.
  task automatic send_data(input logic [15:0] si, input logic [15:0] sq, input logic pend);
    mapper_item_t it;
    int s;
    int prow;
    int k;
    s = next_slot();
    if (!slot_loaded[s]) begin
      it = '0;
      it.op  = OP_MAP_WR;
      it.row = 7'(s);
      it.pos = 6'($urandom);
      send_item(it);
    end
    if (s == SLOTS - 1) begin
      prow = sym_cnt % rows_used();
      for (k = 0; k < NUM_PILOTS; k++) begin
        if (!pil_loaded[prow][k]) begin
          it = '0;
          it.op  = OP_PILOT_WR;
          it.row = 7'(prow);
          it.col = 2'(k);
          it.si  = rand_sample();
          it.sq  = rand_sample();
          send_item(it);
        end
      end
    end
    it = '0;
    it.op   = OP_DATA;
    it.si   = si;
    it.sq   = sq;
    it.pend = pend;
    it.row  = 7'($urandom);  // don't-care fields carry noise on data
    it.col  = 2'($urandom);
    it.pos  = 6'($urandom);
    send_item(it);
  endtask

  // Mostly data; a packet end is likelier on a symbol's last sample than on any
  // other; some table rewrites and ignored transactions.
  task automatic random_step();
    mapper_item_t it;
    int pick;
    logic pend;
    pick = $urandom_range(0, 99);
    it = '0;
    if (pick < 82) begin
      if (next_slot() == SLOTS - 1) pend = ($urandom_range(0, 2) == 0);
      else pend = ($urandom_range(0, 59) == 0);
      send_data(rand_sample(), rand_sample(), pend);
    end else if (pick < 90) begin
      it.op   = OP_MAP_WR;
      it.row  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(SLOTS, 127))
                                             : 7'($urandom_range(0, SLOTS - 1));
      it.pos  = 6'($urandom);
      it.si   = 16'($urandom);
      it.pend = 1'($urandom);
      send_item(it);
    end else if (pick < 97) begin
      it.op   = OP_PILOT_WR;
      it.row  = 7'($urandom);
      it.col  = 2'($urandom);
      it.si   = rand_sample();
      it.sq   = rand_sample();
      it.pend = 1'($urandom);
      send_item(it);
    end else begin
      it = mapper_item_t'(50'({$urandom, $urandom}));
      it.op = OP_UNUSED;
      send_item(it);
    end
  endtask

  // Stop offering, let every queued bin come out, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_row_count(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    row_cfg = v;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_fast = !sink_fast;
      gap = sink_fast ? 0 : $urandom_range(0, 14);
      // mid-run, stall long enough that the block fills and refuses input
      if (!long_hold_done && bins_checked >= 200) begin
        gap = 1000;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
    end
  end

  // Every output transaction is compared with the oldest queued bin.
  always @(posedge clk) begin
    if (rst === 1'b0 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got_bin.i    = m_axis_tdata[15:0];
      got_bin.q    = m_axis_tdata[31:16];
      got_bin.num  = m_axis_tdata[37:32];
      got_bin.last = m_axis_tlast;
      if (bins_due.size() == 0) begin
        log_mismatch($sformatf("unexpected bin %0d i=%h q=%h last=%b",
                               got_bin.num, got_bin.i, got_bin.q, got_bin.last));
      end else begin
        want_bin = bins_due.pop_front();
        if (got_bin !== want_bin)
          log_mismatch($sformatf("bin exp %0d i=%h q=%h last=%b, got %0d i=%h q=%h last=%b",
                                 want_bin.num, want_bin.i, want_bin.q, want_bin.last,
                                 got_bin.num, got_bin.i, got_bin.q, got_bin.last));
      end
      bins_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, random phases at several row counts
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t d;
    mapper_item_t it;
    int r;
    int n;
    int p;
    int target;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 8'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_DATA;
    s_axis_tlast  <= 1'b0;
    row_cfg  = 8'd127;  // reset value of the row count register
    slot_cnt = 0;
    sym_cnt  = 0;
    for (n = 0; n < FFT_SIZE; n++) begin
      sym_i[n] = 16'h0;
      sym_q[n] = 16'h0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part runs with the reset row count
    for (r = 0; r < DIR_COUNT; r++) begin
      d = DIR_ROWS[r];
      for (n = 0; n < d.reps; n++) begin
        if (d.op == OP_DATA) begin
          send_data(d.rnd ? rand_sample() : d.si, d.rnd ? rand_sample() : d.sq, d.pend);
        end else begin
          it = '{op: d.op, si: d.si, sq: d.sq, row: d.row, col: d.col, pos: d.pos,
                 pend: d.pend};
          send_item(it);
        end
      end
      if (d.chk && (last_symbol[d.chk_bin].i !== d.chk_i ||
                    last_symbol[d.chk_bin].q !== d.chk_q))
        log_mismatch($sformatf("directed bin %0d exp i=%h q=%h, model i=%h q=%h",
                               d.chk_bin, d.chk_i, d.chk_q,
                               last_symbol[d.chk_bin].i, last_symbol[d.chk_bin].q));
    end

    // random phases; the row count only changes with the block drained
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      write_row_count((p == PHASES - 1) ? 8'($urandom_range(1, PILOT_ROWS))
                                        : PHASE_ROWS[p]);
      target = items_taken + ((p == 0) ? 130 : 36);
      while (items_taken < target) random_step();
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> ofdm_subcarrier_mapper_core.f
rtl/osm_pkg.sv
rtl/osm_ram.sv
rtl/ofdm_subcarrier_mapper_core.sv
rtl/osm_checker.sv
tb/tb.sv
